// File: rtl/lmac_pkg.sv
// Shared types and constants for the LightMAC Speck64/128 tag generator.
`timescale 1ns / 1ps
`default_nettype none

package lmac_pkg;

    // Cipher geometry
    localparam int unsigned ROUNDS    = 27;
    localparam int unsigned RND_W     = 5;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLK_W     = 64;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAC_KEY_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAC_KEY_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_KEY_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_KEY_HI = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic absorb;     // take the accepted byte into the pending block
        logic start_blk;  // load a counter block and the block key
        logic load_fin;   // load accumulator plus padding and the final key
        logic round;      // run one cipher round
        logic acc_xor;    // fold the cipher result into the accumulator
        logic load_out;   // move the cipher result to the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic blk_full;   // three bytes pending, the next one closes a block
        logic round_last; // the current round is the final one
    } t_sts;

endpackage : lmac_pkg

`default_nettype wire

// File: rtl/lmac_if.sv
// Valid/ready channel interfaces for message bytes and tag results.
`timescale 1ns / 1ps
`default_nettype none

interface lmac_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface : lmac_msg_if

interface lmac_tag_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_value;

    modport source (output valid, output tag_value, input ready);
    modport sink   (input valid, input tag_value, output ready);
endinterface : lmac_tag_if

`default_nettype wire

// File: rtl/lightmac_speck64_tag_top.sv
// Top level of the LightMAC Speck64/128 tag generator.
//
// Message bytes enter on i_msg, one per item; byte_present marks a real byte
// and end_of_message marks the last item of a message (an empty message is a
// single last item with no byte). Tags leave on o_tag, one per message.
// Keys are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle:
// index 0/1 block key low/high, index 2/3 final key low/high.
// Processing: an item that does not close a 4-byte block is only absorbed. An
// item that closes a block starts a block encryption of 27 Speck rounds, one
// round per cycle in the single shared round unit; no new item is taken until
// that block is through.
// A last item adds a final load, 27 final rounds and a handoff to the output
// register, after which the tag is valid.
// The output register holds a finished tag while the receiver stalls and
// further bytes are still taken; a second tag waits in the round unit until
// the register is free. Synchronous reset clears keys, message state and
// output valid.
`timescale 1ns / 1ps
`default_nettype none

module lightmac_speck64_tag_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lmac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lmac_pkg::BLK_W-1:0]     i_cfg_data,
    lmac_msg_if.sink                            i_msg,
    lmac_tag_if.source                          o_tag
);
    import lmac_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lmac_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .i_byte_present   (i_msg.byte_present),
        .i_end_of_message (i_msg.end_of_message),
        .o_in_ready       (i_msg.ready),
        .o_out_valid      (o_tag.valid),
        .i_out_ready      (o_tag.ready),
        .i_sts            (sts),
        .o_cmd            (cmd)
    );

    lmac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_msg.data_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_tag       (o_tag.tag_value)
    );

endmodule : lightmac_speck64_tag_top

`default_nettype wire

// File: rtl/lmac_dp.sv
// Datapath: key registers, message state, Speck round unit and output register.
`timescale 1ns / 1ps
`default_nettype none

module lmac_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lmac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lmac_pkg::BLK_W-1:0]    i_cfg_data,
    input  wire logic [7:0]                    i_data_byte,
    input  wire lmac_pkg::t_cmd                i_cmd,
    output      lmac_pkg::t_sts                o_sts,
    output      logic [lmac_pkg::BLK_W-1:0]    o_tag
);
    import lmac_pkg::*;

    logic [BLK_W-1:0]  r_mac_lo, r_mac_hi, r_fin_lo, r_fin_hi;
    logic [BLK_W-1:0]  r_acc;
    logic [WORD_W-1:0] r_ctr;
    logic [WORD_W-1:0] r_pend;
    logic [1:0]        r_pcnt;
    logic [WORD_W-1:0] r_x0, r_x1, r_k0, r_k1, r_k2, r_k3;
    logic [RND_W-1:0]  r_rnd;
    logic [BLK_W-1:0]  r_tag;

    logic [WORD_W-1:0] n_ctr;
    logic [WORD_W-1:0] n_x0, n_x1, n_k0, n_nk;
    logic [WORD_W-1:0] ctr_be;
    logic [WORD_W-1:0] tail;
    logic [BLK_W-1:0]  fin_in;

    // Next counter value and its big-endian form
    assign n_ctr  = r_ctr + 32'd1;
    assign ctr_be = {n_ctr[7:0], n_ctr[15:8], n_ctr[23:16], n_ctr[31:24]};

    // Leftover bytes followed by the pad byte
    assign tail   = r_pend | (WORD_W'(PAD_BYTE) << {r_pcnt, 3'b000});
    assign fin_in = r_acc ^ {32'd0, tail};

    // One Speck round and one key schedule step
    assign n_x0 = ({r_x0[7:0], r_x0[31:8]} + r_x1) ^ r_k0;
    assign n_x1 = {r_x1[28:0], r_x1[31:29]} ^ n_x0;
    assign n_nk = ({r_k1[7:0], r_k1[31:8]} + r_k0) ^ {{(WORD_W-RND_W){1'b0}}, r_rnd};
    assign n_k0 = {r_k0[28:0], r_k0[31:29]} ^ n_nk;

    assign o_sts.blk_full   = (r_pcnt == 2'd3);
    assign o_sts.round_last = (r_rnd == RND_W'(ROUNDS - 1));
    assign o_tag            = r_tag;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_lo <= '0;
            r_mac_hi <= '0;
            r_fin_lo <= '0;
            r_fin_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAC_KEY_LO: r_mac_lo <= i_cfg_data;
                CFG_MAC_KEY_HI: r_mac_hi <= i_cfg_data;
                CFG_FIN_KEY_LO: r_fin_lo <= i_cfg_data;
                CFG_FIN_KEY_HI: r_fin_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Message state: accumulator, block counter, pending bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_acc  <= '0;
            r_ctr  <= '0;
            r_pend <= '0;
            r_pcnt <= '0;
        end else begin
            if (i_cmd.absorb) begin
                if (r_pcnt == 2'd3) begin
                    r_ctr  <= n_ctr;
                    r_pend <= '0;
                    r_pcnt <= '0;
                end else begin
                    r_pend <= r_pend | (WORD_W'(i_data_byte) << {r_pcnt, 3'b000});
                    r_pcnt <= r_pcnt + 2'd1;
                end
            end
            if (i_cmd.acc_xor) begin
                r_acc <= r_acc ^ {n_x1, n_x0};
            end
        end
    end

    // Cipher state: load, then advance one round a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_blk) begin
            r_x0  <= ctr_be;
            r_x1  <= r_pend | {i_data_byte, 24'd0};
            r_k0  <= r_mac_lo[31:0];
            r_k1  <= r_mac_lo[63:32];
            r_k2  <= r_mac_hi[31:0];
            r_k3  <= r_mac_hi[63:32];
            r_rnd <= '0;
        end else if (i_cmd.load_fin) begin
            r_x0  <= fin_in[31:0];
            r_x1  <= fin_in[63:32];
            r_k0  <= r_fin_lo[31:0];
            r_k1  <= r_fin_lo[63:32];
            r_k2  <= r_fin_hi[31:0];
            r_k3  <= r_fin_hi[63:32];
            r_rnd <= '0;
        end else if (i_cmd.round) begin
            r_x0  <= n_x0;
            r_x1  <= n_x1;
            r_k0  <= n_k0;
            r_k1  <= r_k2;
            r_k2  <= r_k3;
            r_k3  <= n_nk;
            r_rnd <= r_rnd + RND_W'(1);
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_tag <= {r_x1, r_x0};
        end
    end

endmodule : lmac_dp

`default_nettype wire

// File: rtl/lmac_ctrl.sv
// Controller: sequences byte absorption, block and final encryptions, result handoff.
`timescale 1ns / 1ps
`default_nettype none

module lmac_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_byte_present,
    input  wire logic           i_end_of_message,
    output      logic           o_in_ready,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire lmac_pkg::t_sts i_sts,
    output      lmac_pkg::t_cmd o_cmd
);
    import lmac_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BLK   = 3'd1;
    localparam logic [2:0] S_FLOAD = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_ovalid, n_ovalid;
    logic       acc;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign acc         = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.absorb = i_byte_present;
                    n_last       = i_end_of_message;
                    if (i_byte_present && i_sts.blk_full) begin
                        o_cmd.start_blk = 1'b1;
                        n_state         = S_BLK;
                    end else if (i_end_of_message) begin
                        n_state = S_FLOAD;
                    end
                end
            end
            S_BLK: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    o_cmd.acc_xor = 1'b1;
                    n_state       = r_last ? S_FLOAD : S_IDLE;
                end
            end
            S_FLOAD: begin
                o_cmd.load_fin = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on handoff, drop when taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    // A result appears only from the handoff state
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("tag valid rose outside handoff");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_ovalid || i_out_ready))
        else $error("tag register overwritten while stalled");

    // Final load is followed by the rounds in the next cycle
    a_fload_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLOAD) |=> (r_state == S_FIN))
        else $error("final load not followed by rounds");

    // A finished block returns to idle or goes on to finalize
    a_blk_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLK && i_sts.round_last) |=>
            (r_state == S_IDLE || r_state == S_FLOAD))
        else $error("bad exit from block encryption");

endmodule : lmac_ctrl

`default_nettype wire
